[design/cobs_crc_frame_receiver_assert.svh]
// ---------------------------------------------------------------------------
// COBS CRC frame receiver assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef COBS_CRC_FRAME_RECEIVER_ASSERT_SVH
`define COBS_CRC_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define CCFR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CCFR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CCFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[design/ccfr_pkg.sv]
// ---------------------------------------------------------------------------
// COBS CRC frame receiver package
// Status codes, framing constants and the byte-wide CRC-16 update.
// ---------------------------------------------------------------------------
`default_nettype none

package ccfr_pkg;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_CRC_ERROR = 3'd2,
      STATUS_MALFORMED = 3'd3,
      STATUS_OVERFLOW  = 3'd4
   } status_type;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT  = 1'b1;

   localparam logic [7:0]  BYTE_DELIM     = 8'h00;
   localparam logic [7:0]  CODE_FULL_RUN  = 8'hFF;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam int          FRAME_OVERHEAD = 6;

   // Decoded-count values at which the byte leaving the delay is a header byte.
   localparam int POS_SEQ  = 3;
   localparam int POS_CMD0 = 4;
   localparam int POS_CMD1 = 5;

   // CRC-16/CCITT-FALSE update over one byte, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[design/ccfr_ifs.sv]
// ---------------------------------------------------------------------------
// COBS CRC frame receiver channel interfaces
// Valid/ready channels for received bytes and for decoded results.
// ---------------------------------------------------------------------------
`default_nettype none

interface ccfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ccfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [7:0]  payload_byte;
   logic [9:0]  payload_index;
   logic [2:0]  frame_status;
   logic [7:0]  frame_seq;
   logic [15:0] frame_cmd;
   logic [10:0] payload_length;

   modport source (output valid, output item_kind, output payload_byte,
                   output payload_index, output frame_status, output frame_seq,
                   output frame_cmd, output payload_length, input ready);
   modport sink   (input valid, input item_kind, input payload_byte,
                   input payload_index, input frame_status, input frame_seq,
                   input frame_cmd, input payload_length, output ready);
endinterface

`default_nettype wire

[design/cobs_crc_frame_receiver.sv]
// ---------------------------------------------------------------------------
// COBS CRC frame receiver
// Decodes COBS-framed serial bytes, checks CRC-16 and reports frame status.
// ---------------------------------------------------------------------------
// The block takes one received byte per beat on req_bus and accepts a new
// beat in every cycle as long as results are drained. A beat sits in the input
// register once accepted; its result enters the result register when that
// register is empty or being drained (one pass through the COBS decoder and
// the byte-wide CRC update). Each payload byte of a frame comes out as one
// result beat, and the delimiter that closes a non-empty frame comes out as
// one frame-end report with the status, sequence byte, command word and
// payload length. Beats that produce nothing (code bytes, header bytes, CRC
// bytes, an empty delimiter) simply vanish. The byte order of the command and
// CRC words follows csr_write_data as last written; write it only while no
// frame is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cobs_crc_frame_receiver_assert.svh"

module cobs_crc_frame_receiver
   import ccfr_pkg::*;
#(
   parameter int MAX_ENCODED = 1024
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      csr_write_enable,
   input  wire logic      csr_write_data,
   ccfr_req_if.sink       req_bus,
   ccfr_rsp_if.source     rsp_bus
);

   // Counter widths follow from the longest frame that is decoded. The
   // decoded count never exceeds the encoded count, so both share a width.
   localparam int CW = $clog2(MAX_ENCODED + 1);
   // Working width for the payload position arithmetic.
   localparam int XW = (CW > 11) ? CW : 11;

   // Configuration register: 1 means high byte first.
   logic big_endian_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b1;
      end else if (csr_write_enable) begin
         big_endian_ff <= csr_write_data;
      end
   end

   // -----------------------------------------------------------------------
   // Handshake. The input register holds one beat; it moves into the
   // decoder whenever the result register is empty or being drained. While
   // a result waits, the input register still takes one byte, and only then
   // is the source held off.
   // -----------------------------------------------------------------------
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   logic       advance;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.rx_byte;
      end
   end

   // -----------------------------------------------------------------------
   // Frame state.
   // -----------------------------------------------------------------------
   logic [CW-1:0] enc_count_ff,  enc_count_in;
   logic          overflow_ff,   overflow_in;
   logic [7:0]    run_ff,        run_in;
   logic          zero_pend_ff,  zero_pend_in;
   logic [CW-1:0] dec_count_ff,  dec_count_in;
   logic [15:0]   crc_ff,        crc_in;
   logic [7:0]    delay0_ff,     delay0_in;
   logic [7:0]    delay1_ff,     delay1_in;
   logic [7:0]    seq_ff,        seq_in;
   logic [15:0]   cmd_ff,        cmd_in;

   // Result being formed this cycle.
   logic          res_valid;
   logic          res_kind;
   logic [7:0]    res_byte;
   logic [9:0]    res_index;
   status_type    res_status;
   logic [7:0]    res_seq;
   logic [15:0]   res_cmd;
   logic [10:0]   res_length;

   // Decoder helper signals.
   logic          push_en;
   logic [7:0]    push_data;
   logic [XW-1:0] pos_wide;
   logic [15:0]   rx_crc;

   // Position of the byte leaving the delay relative to the payload start;
   // also the payload length when the frame closes.
   assign pos_wide = XW'(dec_count_ff) - XW'(FRAME_OVERHEAD);

   // The received CRC sits in the two delay slots when the delimiter arrives.
   assign rx_crc = big_endian_ff ? {delay0_ff, delay1_ff} : {delay1_ff, delay0_ff};

   always_comb begin
      enc_count_in = enc_count_ff;
      overflow_in  = overflow_ff;
      run_in       = run_ff;
      zero_pend_in = zero_pend_ff;
      dec_count_in = dec_count_ff;
      crc_in       = crc_ff;
      delay0_in    = delay0_ff;
      delay1_in    = delay1_ff;
      seq_in       = seq_ff;
      cmd_in       = cmd_ff;

      res_valid  = 1'b0;
      res_kind   = KIND_PAYLOAD;
      res_byte   = 8'h00;
      res_index  = 10'd0;
      res_status = STATUS_OK;
      res_seq    = 8'h00;
      res_cmd    = 16'h0000;
      res_length = 11'd0;

      push_en   = 1'b0;
      push_data = 8'h00;

      if (in_byte_ff == BYTE_DELIM) begin
         // Delimiter: report a non-empty frame, then start over.
         if (enc_count_ff != '0) begin
            res_valid = 1'b1;
            res_kind  = KIND_REPORT;
            res_seq   = seq_ff;
            res_cmd   = cmd_ff;
            if (dec_count_ff >= CW'(FRAME_OVERHEAD)) begin
               res_length = pos_wide[10:0];
            end
            if (overflow_ff) begin
               res_status = STATUS_OVERFLOW;
            end else if (run_ff != 8'd0) begin
               res_status = STATUS_MALFORMED;
            end else if (dec_count_ff < CW'(FRAME_OVERHEAD)) begin
               res_status = STATUS_SHORT;
            end else if (rx_crc != crc_ff) begin
               res_status = STATUS_CRC_ERROR;
            end
         end
         enc_count_in = '0;
         overflow_in  = 1'b0;
         run_in       = 8'd0;
         zero_pend_in = 1'b0;
         dec_count_in = '0;
         crc_in       = CRC_INIT;
         delay0_in    = 8'h00;
         delay1_in    = 8'h00;
         seq_in       = 8'h00;
         cmd_in       = 16'h0000;
      end else if (!overflow_ff) begin
         if (enc_count_ff >= CW'(MAX_ENCODED)) begin
            // Too many bytes: drop the rest of the frame undecoded.
            overflow_in = 1'b1;
         end else begin
            enc_count_in = enc_count_ff + CW'(1);
            if (run_ff == 8'd0) begin
               // Code byte: the previous short run implies a zero here.
               push_en      = zero_pend_ff;
               push_data    = 8'h00;
               zero_pend_in = (in_byte_ff != CODE_FULL_RUN);
               run_in       = in_byte_ff - 8'd1;
            end else begin
               push_en   = 1'b1;
               push_data = in_byte_ff;
               run_in    = run_ff - 8'd1;
            end
         end
      end

      // Two-byte delay: the byte leaving it feeds the CRC and is either a
      // header byte or a payload byte. The last two bytes, the CRC itself,
      // never leave before the delimiter.
      if (push_en) begin
         if (dec_count_ff >= CW'(2)) begin
            crc_in = crc_byte(crc_ff, delay0_ff);
            if (dec_count_ff == CW'(POS_SEQ)) begin
               seq_in = delay0_ff;
            end else if (dec_count_ff == CW'(POS_CMD0)) begin
               if (big_endian_ff) begin
                  cmd_in[15:8] = delay0_ff;
               end else begin
                  cmd_in[7:0] = delay0_ff;
               end
            end else if (dec_count_ff == CW'(POS_CMD1)) begin
               if (big_endian_ff) begin
                  cmd_in[7:0] = delay0_ff;
               end else begin
                  cmd_in[15:8] = delay0_ff;
               end
            end else if (dec_count_ff >= CW'(FRAME_OVERHEAD)) begin
               res_valid = 1'b1;
               res_kind  = KIND_PAYLOAD;
               res_byte  = delay0_ff;
               res_index = pos_wide[9:0];
            end
         end
         delay0_in    = delay1_ff;
         delay1_in    = push_data;
         dec_count_in = dec_count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enc_count_ff <= '0;
         overflow_ff  <= 1'b0;
         run_ff       <= 8'd0;
         zero_pend_ff <= 1'b0;
         dec_count_ff <= '0;
         crc_ff       <= CRC_INIT;
         delay0_ff    <= 8'h00;
         delay1_ff    <= 8'h00;
         seq_ff       <= 8'h00;
         cmd_ff       <= 16'h0000;
      end else if (advance) begin
         enc_count_ff <= enc_count_in;
         overflow_ff  <= overflow_in;
         run_ff       <= run_in;
         zero_pend_ff <= zero_pend_in;
         dec_count_ff <= dec_count_in;
         crc_ff       <= crc_in;
         delay0_ff    <= delay0_in;
         delay1_ff    <= delay1_in;
         seq_ff       <= seq_in;
         cmd_ff       <= cmd_in;
      end
   end

   // -----------------------------------------------------------------------
   // Result register.
   // -----------------------------------------------------------------------
   logic        kind_ff;
   logic [7:0]  byte_ff;
   logic [9:0]  index_ff;
   logic [2:0]  status_ff;
   logic [7:0]  seq_out_ff;
   logic [15:0] cmd_out_ff;
   logic [10:0] length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= res_valid;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         kind_ff    <= res_kind;
         byte_ff    <= res_byte;
         index_ff   <= res_index;
         status_ff  <= res_status;
         seq_out_ff <= res_seq;
         cmd_out_ff <= res_cmd;
         length_ff  <= res_length;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.item_kind      = kind_ff;
   assign rsp_bus.payload_byte   = byte_ff;
   assign rsp_bus.payload_index  = index_ff;
   assign rsp_bus.frame_status   = status_ff;
   assign rsp_bus.frame_seq      = seq_out_ff;
   assign rsp_bus.frame_cmd      = cmd_out_ff;
   assign rsp_bus.payload_length = length_ff;

   // -----------------------------------------------------------------------
   // Assertions.
   // -----------------------------------------------------------------------
   // The encoded count saturates at the frame limit.
   `CCFR_ASSERT_IMPL(a_enc_bound, clock, reset, 1'b1, enc_count_ff <= CW'(MAX_ENCODED), "encoded count beyond limit")
   // Every decoded byte comes from at least one encoded byte.
   `CCFR_ASSERT_IMPL(a_dec_bound, clock, reset, 1'b1, dec_count_ff <= enc_count_ff, "decoded count exceeds encoded count")
   // A full input register behind a stalled result must hold off the source.
   `CCFR_ASSERT_IMPL(a_backpressure, clock, reset, in_valid_ff && out_valid_ff && !rsp_bus.ready, !req_bus.ready, "input taken while pipeline is full")
   // A delimiter always leaves the frame state cleared.
   `CCFR_ASSERT_NEXT(a_delim_clear, clock, reset, advance && (in_byte_ff == BYTE_DELIM), (enc_count_ff == '0) && (crc_ff == CRC_INIT), "frame state not cleared by delimiter")

endmodule

`default_nettype wire
